[design/dtsb_pkg.sv]
package dtsb_pkg;

    // character codes that steer the parser
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // saturation limits of the counters
    localparam logic [7:0] DIGIT_MAX    = 8'hFF;
    localparam logic [6:0] FRACTION_MAX = 7'h7F;

    // widths of the result fields
    localparam int unsigned HALF_W = 64;
    localparam int unsigned EXT_W  = 2 * HALF_W;

    // one input word after the input register
    typedef struct packed {
        logic       is_end;
        logic [7:0] char_code;
    } t_item;

    // one result word, lowest field in the lowest bits
    typedef struct packed {
        logic [6:0]        fraction_digits;
        logic [7:0]        digit_total;
        logic              is_positive;
        logic [HALF_W-1:0] mantissa_high;
        logic [HALF_W-1:0] mantissa_low;
    } t_result;

endpackage

[design/dtsb_in_reg.sv]
module dtsb_in_reg
    import dtsb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    logic  r_valid;
    t_item r_item;

    // register is free when empty or being drained this cycle
    assign o_ready = !r_valid || i_take;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[design/dtsb_accum.sv]
module dtsb_accum
    import dtsb_pkg::*;
#(
    parameter int unsigned MANTISSA_BYTES = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    localparam int unsigned MW = 8 * MANTISSA_BYTES;

    logic [MW-1:0] r_mant,       n_mant;
    logic [7:0]    r_digit_cnt,  n_digit_cnt;
    logic [6:0]    r_frac_cnt,   n_frac_cnt;
    logic          r_point,      n_point;
    logic          r_stopped,    n_stopped;
    logic          r_first,      n_first;
    logic          r_negative,   n_negative;

    logic [3:0]      w_offset;
    logic [MW-1:0]   w_mant_next;
    logic [EXT_W-1:0] w_mant_ext;

    // times ten plus digit as shift-and-add, wraps at the mantissa width
    assign w_offset    = 4'(i_item.char_code - CHAR_ZERO);
    assign w_mant_next = (r_mant << 3) + (r_mant << 1) + MW'(w_offset);

    // next state for one character or the end word
    always_comb begin
        n_mant      = r_mant;
        n_digit_cnt = r_digit_cnt;
        n_frac_cnt  = r_frac_cnt;
        n_point     = r_point;
        n_stopped   = r_stopped;
        n_first     = r_first;
        n_negative  = r_negative;
        if (i_item.is_end) begin
            n_mant      = '0;
            n_digit_cnt = '0;
            n_frac_cnt  = '0;
            n_point     = 1'b0;
            n_stopped   = 1'b0;
            n_first     = 1'b1;
            n_negative  = 1'b0;
        end else if (r_first && i_item.char_code == CHAR_MINUS) begin
            n_first    = 1'b0;
            n_negative = 1'b1;
        end else if (r_first && i_item.char_code == CHAR_PLUS) begin
            n_first = 1'b0;
        end else begin
            n_first = 1'b0;
            if (!r_stopped) begin
                if (i_item.char_code == CHAR_POINT) begin
                    n_point = 1'b1;
                end else if (i_item.char_code inside {[CHAR_ZERO:CHAR_NINE]}) begin
                    n_mant = w_mant_next;
                    if (r_digit_cnt != DIGIT_MAX) begin
                        n_digit_cnt = r_digit_cnt + 8'd1;
                    end
                    if (r_point && r_frac_cnt != FRACTION_MAX) begin
                        n_frac_cnt = r_frac_cnt + 7'd1;
                    end
                end else begin
                    n_stopped = 1'b1;
                end
            end
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mant      <= '0;
            r_digit_cnt <= '0;
            r_frac_cnt  <= '0;
            r_point     <= 1'b0;
            r_stopped   <= 1'b0;
            r_first     <= 1'b1;
            r_negative  <= 1'b0;
        end else if (i_fire) begin
            r_mant      <= n_mant;
            r_digit_cnt <= n_digit_cnt;
            r_frac_cnt  <= n_frac_cnt;
            r_point     <= n_point;
            r_stopped   <= n_stopped;
            r_first     <= n_first;
            r_negative  <= n_negative;
        end
    end

    // result as seen by the end word
    assign w_mant_ext = EXT_W'(r_mant);

    always_comb begin
        o_result.mantissa_low    = w_mant_ext[HALF_W-1:0];
        o_result.mantissa_high   = w_mant_ext[EXT_W-1:HALF_W];
        o_result.is_positive     = !r_negative;
        o_result.digit_total     = (r_digit_cnt == 8'd0) ? 8'd1 : r_digit_cnt;
        o_result.fraction_digits = r_frac_cnt;
    end

endmodule

[design/dtsb_out_reg.sv]
module dtsb_out_reg
    import dtsb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // slot can take a new word when empty or being read out
    assign o_free = !r_valid || i_ready;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[design/decimal_text_to_scaled_binary.sv]
// Decimal text to scaled binary converter.
// Input stream: one character per word. tdata carries the ASCII code and
// tlast marks the end word (its tdata is ignored). A leading sign, a point
// and digits are parsed; the first other character freezes the value.
// Output stream: one word per end word. tdata carries the mantissa, sign,
// digit total and fraction digit count.
// Throughput: one input word per cycle while no end word waits for the result
// register; character words keep flowing while a finished result is still
// waiting on the output. The 128-bit times-ten-plus-digit shift-and-add
// between the input register and the parser state sets the cycle.
// Output: the result register loads as the end word leaves the input
// register; an end word leaves only when the result register is free.
// Reset: both registers empty, the parser at the start of a new number.
// Stall: while the output is held, character words keep flowing into the
// parser; a following end word waits in the input register, and input
// ready drops only then.
module decimal_text_to_scaled_binary
    import dtsb_pkg::*;
#(
    parameter int unsigned MANTISSA_BYTES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // char_code[7:0]
    input  logic         s_axis_tlast,  // is_end
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata   // mantissa_low[63:0], mantissa_high[127:64],
                                        // is_positive[128], digit_total[136:129],
                                        // fraction_digits[143:137]
);

    t_item   w_in_item;
    t_item   w_item;
    logic    w_item_valid;
    logic    w_out_free;
    logic    w_take;
    t_result w_result;
    t_result w_out_result;

    assign w_in_item.char_code = s_axis_tdata;
    assign w_in_item.is_end    = s_axis_tlast;

    // an end word moves on only when the result register has room
    assign w_take = w_item_valid && (!w_item.is_end || w_out_free);

    dtsb_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .o_valid (w_item_valid),
        .o_item  (w_item),
        .i_take  (w_take)
    );

    dtsb_accum #(
        .MANTISSA_BYTES (MANTISSA_BYTES)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_take),
        .i_item   (w_item),
        .o_result (w_result)
    );

    dtsb_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_take && w_item.is_end),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_out_result)
    );

    // pack the result word, mantissa_low in the lowest bits
    assign m_axis_tdata = {w_out_result.fraction_digits, w_out_result.digit_total,
                           w_out_result.is_positive, w_out_result.mantissa_high,
                           w_out_result.mantissa_low};

endmodule

[design/dtsb_checker.sv]
module dtsb_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata
);

    logic [7:0] w_total;
    logic [6:0] w_frac;

    assign w_total = m_axis_tdata[136:129];
    assign w_frac  = m_axis_tdata[143:137];

    // output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a held result word keeps its contents
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // digit total never zero
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_total != 8'd0)
        else $error("digit total is zero");

    // fractional digits never exceed the digit total
    a_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> {1'b0, w_frac} <= w_total)
        else $error("fraction count above digit total");

    // input is ready right after reset
    a_ready_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind decimal_text_to_scaled_binary dtsb_checker u_dtsb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/sv/decimal_text_to_scaled_binary_test.sv]
`timescale 1ns / 1ps

module decimal_text_to_scaled_binary_test;
    import dtsb_pkg::*;

    localparam int unsigned ITEM_TARGET   = 1600;
    localparam int unsigned CALM_WORDS    = 150;
    localparam int unsigned WATCHDOG_MAX  = 1000;
    localparam int unsigned DRAIN_CYCLES  = 8;

    typedef enum int {SIGN_NONE, SIGN_MINUS, SIGN_PLUS} t_sign;

    // one input word: character code and end flag
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_char_word;

    logic         i_clk          = 1'b0;
    logic         i_rst_n        = 1'b0;
    logic         s_axis_tvalid  = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata   = 8'h00;  // char_code[7:0]
    logic         s_axis_tlast   = 1'b0;   // is_end
    logic         m_axis_tvalid;
    logic         m_axis_tready  = 1'b0;
    logic [143:0] m_axis_tdata;            // mantissa_low[63:0], mantissa_high[127:64],
                                           // is_positive[128], digit_total[136:129],
                                           // fraction_digits[143:137]

    t_char_word   pending_words[$];
    t_result      expected_results[$];
    int unsigned  words_total    = 0;
    int unsigned  words_accepted = 0;
    int unsigned  err_count      = 0;
    int unsigned  quiet_cycles   = 0;
    int unsigned  idle_pct       = 0;
    logic         calm           = 1'b0;

    // number parser state, mirrored from the block
    logic [127:0] acc_mantissa   = '0;
    logic [7:0]   acc_digits     = '0;
    logic [6:0]   acc_fraction   = '0;
    logic         point_seen     = 1'b0;
    logic         parse_stopped  = 1'b0;
    logic         first_char     = 1'b1;
    logic         minus_seen     = 1'b0;

    decimal_text_to_scaled_binary u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic push_word(input logic [7:0] ch, input logic last);
        t_char_word w;
        w.ch   = ch;
        w.last = last;
        pending_words.push_back(w);
    endtask

    // characters of a string followed by an end word with random payload
    task automatic push_text(input string s);
        logic [7:0] filler;
        filler = $urandom_range(255);
        for (int i = 0; i < s.len(); i++) push_word(s[i], 1'b0);
        push_word(filler, 1'b1);
    endtask

    // signed decimal number with optional point and injected stray characters
    task automatic add_number(input int n_digits, input t_sign sign, input int point_at,
                              input int n_noise);
        logic [7:0] seq[$];
        logic [7:0] rnd;
        int         pos;
        if (sign == SIGN_MINUS) begin
            seq.push_back(CHAR_MINUS);
        end else if (sign == SIGN_PLUS) begin
            seq.push_back(CHAR_PLUS);
        end
        for (int i = 0; i <= n_digits; i++) begin
            if (i == point_at) seq.push_back(CHAR_POINT);
            if (i < n_digits) begin
                rnd = $urandom_range(9);
                seq.push_back(CHAR_ZERO + rnd);
            end
        end
        repeat (n_noise) begin
            pos = $urandom_range(seq.size());
            rnd = $urandom_range(255);
            case ($urandom_range(3))
                0: seq.insert(pos, CHAR_POINT);
                1: seq.insert(pos, CHAR_MINUS);
                2: seq.insert(pos, CHAR_PLUS);
                default: seq.insert(pos, rnd);
            endcase
        end
        foreach (seq[i]) push_word(seq[i], 1'b0);
        rnd = $urandom_range(255);
        push_word(rnd, 1'b1);
    endtask

    // mostly clean numbers, some past 64 and 128 bits, some broken
    task automatic add_random_number();
        int    sel;
        int    n;
        int    point_at;
        int    n_noise;
        t_sign sign;
        sel = $urandom_range(99);
        if (sel < 70) begin
            n = $urandom_range(12);
        end else if (sel < 92) begin
            n = $urandom_range(24, 13);
        end else begin
            n = $urandom_range(45, 25);
        end
        sign     = t_sign'($urandom_range(2));
        point_at = $urandom_range(n + n / 2 + 1);
        n_noise  = ($urandom_range(99) < 22) ? $urandom_range(3, 1) : 0;
        add_number(n, sign, point_at, n_noise);
    endtask

    // expected behavior for one accepted word
    task automatic predict_char(input logic [7:0] ch, input logic last);
        t_result r;
        logic    taken;
        if (last) begin
            r.mantissa_low    = acc_mantissa[63:0];
            r.mantissa_high   = acc_mantissa[127:64];
            r.is_positive     = !minus_seen;
            r.digit_total     = (acc_digits == 8'd0) ? 8'd1 : acc_digits;
            r.fraction_digits = acc_fraction;
            expected_results.push_back(r);
            acc_mantissa  = '0;
            acc_digits    = '0;
            acc_fraction  = '0;
            point_seen    = 1'b0;
            parse_stopped = 1'b0;
            first_char    = 1'b1;
            minus_seen    = 1'b0;
        end else begin
            taken = 1'b0;
            // a sign counts only as the very first character
            if (first_char) begin
                first_char = 1'b0;
                if (ch == CHAR_MINUS) begin
                    minus_seen = 1'b1;
                    taken      = 1'b1;
                end else if (ch == CHAR_PLUS) begin
                    taken = 1'b1;
                end
            end
            if (!taken && !parse_stopped) begin
                if (ch == CHAR_POINT) begin
                    point_seen = 1'b1;
                end else if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
                    parse_stopped = 1'b1;
                end else begin
                    acc_mantissa = acc_mantissa * 128'd10 + {120'd0, ch - CHAR_ZERO};
                    if (acc_digits != DIGIT_MAX) acc_digits = acc_digits + 8'd1;
                    if (point_seen && acc_fraction != FRACTION_MAX)
                        acc_fraction = acc_fraction + 7'd1;
                end
            end
        end
    endtask

    task automatic check_result(input logic [143:0] data);
        t_result got;
        t_result exp_r;
        got = data;
        if (expected_results.size() == 0) begin
            $error("result word with none expected: %h", data);
            err_count++;
        end else begin
            exp_r = expected_results.pop_front();
            if (got.mantissa_low !== exp_r.mantissa_low) begin
                $error("mantissa_low: expected %h, got %h",
                       exp_r.mantissa_low, got.mantissa_low);
                err_count++;
            end
            if (got.mantissa_high !== exp_r.mantissa_high) begin
                $error("mantissa_high: expected %h, got %h",
                       exp_r.mantissa_high, got.mantissa_high);
                err_count++;
            end
            if (got.is_positive !== exp_r.is_positive) begin
                $error("is_positive: expected %b, got %b",
                       exp_r.is_positive, got.is_positive);
                err_count++;
            end
            if (got.digit_total !== exp_r.digit_total) begin
                $error("digit_total: expected %0d, got %0d",
                       exp_r.digit_total, got.digit_total);
                err_count++;
            end
            if (got.fraction_digits !== exp_r.fraction_digits) begin
                $error("fraction_digits: expected %0d, got %0d",
                       exp_r.fraction_digits, got.fraction_digits);
                err_count++;
            end
        end
    endtask

    // idle density changes at random, none near the end
    always @(posedge i_clk) begin
        int unsigned pick;
        pick = $urandom_range(2);
        calm <= (pending_words.size() < CALM_WORDS);
        if ($urandom_range(127) == 0) begin
            idle_pct <= (pick == 0) ? 0 : (pick == 1) ? 8 : 30;
        end
    end

    // word driver
    always @(posedge i_clk) begin
        static int unsigned send_gap = 0;
        t_char_word w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap > 0 && !calm) begin
                send_gap = send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                send_gap = 0;
                w = pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= w.ch;
                s_axis_tlast  <= w.last;
                if ($urandom_range(99) < idle_pct) send_gap = $urandom_range(15, 1);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver with stall bursts
    always @(posedge i_clk) begin
        static int unsigned stall_left = 0;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0 && !calm) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            stall_left = 0;
            m_axis_tready <= 1'b1;
            if ($urandom_range(99) < idle_pct) stall_left = $urandom_range(15, 1);
        end
    end

    // monitor: predict on input words, check output words, watch for hangs
    always @(posedge i_clk) begin
        logic moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_char(s_axis_tdata, s_axis_tlast);
                words_accepted++;
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        // directed: empty text, signs, point cases, code zero and all ones
        push_text("");
        push_text("-0");
        push_text("+9.5");
        push_text("1.2.3");
        push_text("7-3");
        push_word(8'h00, 1'b0);
        push_text("5");
        push_word(8'hFF, 1'b0);
        push_text("");

        // counter saturation and mantissa wrap
        add_number(260, SIGN_MINUS, 2, 0);
        add_number(140, SIGN_NONE, 0, 0);
        add_number(255, SIGN_PLUS, 300, 0);
        add_number(45, SIGN_NONE, 46, 0);

        while (pending_words.size() < ITEM_TARGET) add_random_number();
        words_total = pending_words.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_accepted < words_total || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
